/* rtl/gptl_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gptl_pkg
// Types, register indexes and constants shared by the ground-plane target
// locator modules.
// ---------------------------------------------------------------------------
package gptl_pkg;

    localparam int unsigned CfgIdxW = 3;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_FOCAL_X  = 3'd0,
        CFG_FOCAL_Y  = 3'd1,
        CFG_CENTER_X = 3'd2,
        CFG_CENTER_Y = 3'd3,
        CFG_SIN_TILT = 3'd4,
        CFG_COS_TILT = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_SAT      = 2'd2
    } t_status;

    localparam logic [31:0] Cap31 = 32'h7FFF_FFFF;
    localparam int unsigned QueueDepth = 2;

    typedef struct packed {
        logic        action;
        logic [31:0] range_value;
        logic [11:0] top_left_x;
        logic [11:0] top_left_y;
        logic [11:0] top_right_x;
        logic [11:0] top_right_y;
        logic [11:0] bottom_left_x;
        logic [11:0] bottom_left_y;
        logic [11:0] bottom_right_x;
        logic [11:0] bottom_right_y;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [1:0]         status;
    } t_out_word;

    // Job passed from the front end to the back end.
    typedef struct packed {
        logic [13:0] sum_x;
        logic [13:0] sum_y;
        logic [31:0] range;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RX_INIT,
        S_RX_DIV,
        S_RY_INIT,
        S_RY_DIV,
        S_DEN_MUL,
        S_DEN_CHK,
        S_T_DIV,
        S_T_DONE,
        S_PX_MUL,
        S_PY_MUL,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

/* rtl/gptl_front.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gptl_front
// Accepts input words, keeps the newest distance and queues region jobs
// carrying the corner sums and the distance in force, when it is nonzero.
// ---------------------------------------------------------------------------
module gptl_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  gptl_pkg::t_in_word  i_data,
    output logic                o_job_valid,
    input  wire                 i_job_ready,
    output gptl_pkg::t_job      o_job
);

    logic [31:0]    r_range;
    gptl_pkg::t_job r_q [gptl_pkg::QueueDepth];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           w_acc;
    logic           w_push;
    logic           w_pop;
    gptl_pkg::t_job w_job;

    assign o_ready     = (r_cnt != 2'd2);
    assign w_acc       = i_valid && o_ready;
    assign w_push      = w_acc && i_data.action && (r_range != 32'd0);
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_pop       = o_job_valid && i_job_ready;
    assign o_job       = r_q[r_rp];

    always_comb begin
        w_job.sum_x = 14'(i_data.top_left_x) + 14'(i_data.top_right_x)
                    + 14'(i_data.bottom_left_x) + 14'(i_data.bottom_right_x);
        w_job.sum_y = 14'(i_data.top_left_y) + 14'(i_data.top_right_y)
                    + 14'(i_data.bottom_left_y) + 14'(i_data.bottom_right_y);
        w_job.range = r_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range <= '0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (w_acc && !i_data.action) begin
                r_range <= i_data.range_value;
            end
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

endmodule
`default_nettype wire

/* rtl/gptl_back.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gptl_back
// Works one job at a time: two ray divisions, the plane denominator and,
// unless it is zero, the range division and two products, sharing one
// restoring divider that yields one quotient bit per cycle.
// ---------------------------------------------------------------------------
module gptl_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_job_valid,
    output logic                 o_job_ready,
    input  gptl_pkg::t_job       i_job,
    input  wire  [31:0]          i_focal_x,
    input  wire  [31:0]          i_focal_y,
    input  wire  [31:0]          i_center_x,
    input  wire  [31:0]          i_center_y,
    input  wire  signed [17:0]   i_sin,
    input  wire  signed [17:0]   i_cos,
    output logic                 o_valid,
    input  wire                  i_ready,
    output gptl_pkg::t_out_word  o_data
);

    gptl_pkg::t_state r_state, n_state;
    gptl_pkg::t_job   r_job;
    logic [63:0]      r_num;
    logic [50:0]      r_den;
    logic [51:0]      r_rem;
    logic [6:0]       r_cnt;
    logic             r_neg;
    logic             r_dz;
    logic             r_sat;
    logic [31:0]      r_rx;
    logic             r_rxn;
    logic [31:0]      r_ry;
    logic             r_ryn;
    logic signed [50:0] r_dv;
    logic [31:0]      r_t;
    logic             r_tn;
    logic [63:0]      r_prod;
    logic signed [31:0] r_px;
    logic             r_par;
    gptl_pkg::t_out_word r_out;
    logic             r_ov;

    logic signed [33:0] w_diff;
    logic [33:0]      w_mag;
    logic [51:0]      w_shift;
    logic [52:0]      w_trial;
    logic [31:0]      w_q;
    logic             w_qbig;
    logic [31:0]      w_mul_a;
    logic [31:0]      w_m;
    logic             w_mbig;
    logic [50:0]      w_dmag;
    logic [31:0]      w_ry_mag;
    logic signed [32:0] w_ry_s;
    logic signed [50:0] w_sprod;
    logic             w_start;
    logic             w_free;

    assign w_free      = !r_ov || i_ready;
    assign o_job_ready = (r_state == gptl_pkg::S_IDLE);
    assign w_start     = i_job_valid && o_job_ready;
    assign o_valid     = r_ov;
    assign o_data      = r_out;

    always_comb begin
        if (r_state == gptl_pkg::S_RX_INIT) begin
            w_diff = $signed({6'b0, r_job.sum_x, 14'b0}) - $signed({2'b0, i_center_x});
        end else begin
            w_diff = $signed({6'b0, r_job.sum_y, 14'b0}) - $signed({2'b0, i_center_y});
        end
        w_mag   = w_diff[33] ? 34'(-w_diff) : 34'(w_diff);
        w_shift = {r_rem[50:0], r_num[63]};
        w_trial = {1'b0, w_shift} - {2'b0, r_den};
        w_qbig  = (r_num[63:31] != 33'd0);
        w_q     = w_qbig ? gptl_pkg::Cap31 : r_num[31:0];
        w_mul_a = (r_state == gptl_pkg::S_PX_MUL) ? r_rx : r_ry;
        w_mbig  = (r_prod[63:47] != 17'd0);
        w_m     = w_mbig ? gptl_pkg::Cap31 : r_prod[47:16];
        w_dmag  = r_dv[50] ? 51'(-r_dv) : 51'(r_dv);
        if (r_den == '0) begin
            w_ry_mag = r_dz ? 32'd0 : gptl_pkg::Cap31;
        end else begin
            w_ry_mag = w_q;
        end
        w_ry_s  = r_neg ? -$signed({1'b0, w_ry_mag}) : $signed({1'b0, w_ry_mag});
        w_sprod = i_sin * w_ry_s;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gptl_pkg::S_IDLE:    if (w_start) n_state = gptl_pkg::S_RX_INIT;
            gptl_pkg::S_RX_INIT: n_state = gptl_pkg::S_RX_DIV;
            gptl_pkg::S_RX_DIV:  if (r_cnt == 7'd0) n_state = gptl_pkg::S_RY_INIT;
            gptl_pkg::S_RY_INIT: n_state = gptl_pkg::S_RY_DIV;
            gptl_pkg::S_RY_DIV:  if (r_cnt == 7'd0) n_state = gptl_pkg::S_DEN_MUL;
            gptl_pkg::S_DEN_MUL: n_state = gptl_pkg::S_DEN_CHK;
            gptl_pkg::S_DEN_CHK: n_state = (r_dv == '0) ? gptl_pkg::S_OUT
                                                        : gptl_pkg::S_T_DIV;
            gptl_pkg::S_T_DIV:   if (r_cnt == 7'd0) n_state = gptl_pkg::S_T_DONE;
            gptl_pkg::S_T_DONE:  n_state = gptl_pkg::S_PX_MUL;
            gptl_pkg::S_PX_MUL:  n_state = gptl_pkg::S_PY_MUL;
            gptl_pkg::S_PY_MUL:  n_state = gptl_pkg::S_OUT;
            gptl_pkg::S_OUT:     if (w_free) n_state = gptl_pkg::S_IDLE;
            default:             n_state = gptl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gptl_pkg::S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == gptl_pkg::S_OUT && w_free) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            gptl_pkg::S_IDLE: begin
                if (w_start) begin
                    r_job <= i_job;
                    r_sat <= 1'b0;
                end
            end
            gptl_pkg::S_RX_INIT, gptl_pkg::S_RY_INIT: begin
                r_num <= {14'b0, w_mag, 16'b0};
                r_den <= {19'b0, (r_state == gptl_pkg::S_RX_INIT) ? i_focal_x : i_focal_y};
                r_rem <= '0;
                r_cnt <= 7'd63;
                r_neg <= w_diff[33];
                r_dz  <= (w_mag == 34'd0);
            end
            gptl_pkg::S_RX_DIV, gptl_pkg::S_RY_DIV, gptl_pkg::S_T_DIV: begin
                r_cnt <= r_cnt - 7'd1;
                if (!w_trial[52]) begin
                    r_rem <= w_trial[51:0];
                    r_num <= {r_num[62:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_num <= {r_num[62:0], 1'b0};
                end
            end
            default: ;
        endcase

        // Division results are taken in the cycle after the last step.
        if (r_state == gptl_pkg::S_RY_INIT || r_state == gptl_pkg::S_DEN_MUL) begin
            if (r_den == '0) begin
                if (r_state == gptl_pkg::S_RY_INIT) begin
                    r_rx <= r_dz ? 32'd0 : gptl_pkg::Cap31;
                    r_rxn <= r_neg && !r_dz;
                end else begin
                    r_ry <= r_dz ? 32'd0 : gptl_pkg::Cap31;
                    r_ryn <= r_neg && !r_dz;
                end
                r_sat <= 1'b1;
            end else begin
                if (r_state == gptl_pkg::S_RY_INIT) begin
                    r_rx <= w_q;
                    r_rxn <= r_neg && (w_q != 32'd0);
                end else begin
                    r_ry <= w_q;
                    r_ryn <= r_neg && (w_q != 32'd0);
                end
                if (w_qbig) r_sat <= 1'b1;
            end
        end

        if (r_state == gptl_pkg::S_DEN_CHK) begin
            r_num <= {r_job.range, 32'b0};
            r_den <= w_dmag;
            r_rem <= '0;
            r_cnt <= 7'd63;
            r_neg <= r_dv[50];
            r_par <= (r_dv == '0);
        end

        if (r_state == gptl_pkg::S_DEN_MUL) begin
            // ry is taken from the divider this cycle, so use it directly.
            r_dv <= w_sprod + (51'(i_cos) <<< 16);
        end

        if (r_state == gptl_pkg::S_T_DONE) begin
            r_t  <= w_q;
            r_tn <= r_neg && (w_q != 32'd0);
            if (w_qbig) r_sat <= 1'b1;
        end

        if (r_state == gptl_pkg::S_PX_MUL || r_state == gptl_pkg::S_PY_MUL) begin
            r_prod <= 64'(w_mul_a) * 64'(r_t);
        end

        if (r_state == gptl_pkg::S_PY_MUL) begin
            r_px <= (r_rxn != r_tn && w_m != 32'd0) ? -$signed(w_m) : $signed(w_m);
            if (w_mbig) r_sat <= 1'b1;
        end

        if (r_state == gptl_pkg::S_OUT && w_free) begin
            if (r_par) begin
                r_out.point_x <= r_rx == 32'd0 ? 32'sd0
                               : (r_rxn ? -$signed(gptl_pkg::Cap31) : $signed(gptl_pkg::Cap31));
                r_out.point_y <= r_ry == 32'd0 ? 32'sd0
                               : (r_ryn ? -$signed(gptl_pkg::Cap31) : $signed(gptl_pkg::Cap31));
                r_out.point_z <= $signed(gptl_pkg::Cap31);
                r_out.status  <= gptl_pkg::ST_PARALLEL;
            end else begin
                r_out.point_x <= r_px;
                r_out.point_y <= (r_ryn != r_tn && w_m != 32'd0) ? -$signed(w_m)
                                                                  : $signed(w_m);
                r_out.point_z <= r_tn ? -$signed(r_t) : $signed(r_t);
                r_out.status  <= (r_sat || w_mbig) ? gptl_pkg::ST_SAT : gptl_pkg::ST_OK;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/ground_plane_target_locator.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// ground_plane_target_locator
// Locates a region's centroid on a tilted ground plane from pinhole
// intrinsics and the newest measured distance.
// ---------------------------------------------------------------------------
// A distance word gives no result. A region word gives one result when a
// nonzero distance is held, and none otherwise. The back end runs three
// 64-step divisions on one shared bit-serial divider, or two when the ray
// lies parallel to the plane; a two-entry queue lets the front end keep
// taking words meanwhile until it is full.
module ground_plane_target_locator (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  gptl_pkg::t_in_word   i_data,
    output logic                 o_valid,
    input  wire                  i_ready,
    output gptl_pkg::t_out_word  o_data,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [2:0]           i_cfg_index,
    input  wire  [31:0]          i_cfg_data
);

    logic [31:0]        r_fx, r_fy, r_cx, r_cy;
    logic signed [17:0] r_sin, r_cos;
    logic               w_jv, w_jr;
    gptl_pkg::t_job     w_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx  <= 32'h0001_0000;
            r_fy  <= 32'h0001_0000;
            r_cx  <= '0;
            r_cy  <= '0;
            r_sin <= '0;
            r_cos <= 18'sh10000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gptl_pkg::CFG_FOCAL_X:  r_fx  <= i_cfg_data;
                gptl_pkg::CFG_FOCAL_Y:  r_fy  <= i_cfg_data;
                gptl_pkg::CFG_CENTER_X: r_cx  <= i_cfg_data;
                gptl_pkg::CFG_CENTER_Y: r_cy  <= i_cfg_data;
                gptl_pkg::CFG_SIN_TILT: r_sin <= i_cfg_data[17:0];
                gptl_pkg::CFG_COS_TILT: r_cos <= i_cfg_data[17:0];
                default: ;
            endcase
        end
    end

    gptl_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_job_valid(w_jv), .i_job_ready(w_jr), .o_job(w_job)
    );

    gptl_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(w_jv), .o_job_ready(w_jr), .i_job(w_job),
        .i_focal_x(r_fx), .i_focal_y(r_fy), .i_center_x(r_cx), .i_center_y(r_cy),
        .i_sin(r_sin), .i_cos(r_cos),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

endmodule
`default_nettype wire

/* tb/sv/tb_ground_plane_target_locator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ground_plane_target_locator
// Drives range and region words under several camera settings and checks
// every result word with a local fixed-point model or a fixed value.
// ---------------------------------------------------------------------------
module tb_ground_plane_target_locator;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_FIXED
    } t_check;

    typedef struct {
        gptl_pkg::t_in_word  w;
        t_check              chk;
        gptl_pkg::t_out_word res;
    } t_row;

    localparam int unsigned SettleCycles = 1500;
    localparam int unsigned WatchLimit   = 20000;
    localparam int unsigned PhaseWords   = 150;
    localparam int unsigned NumPhases    = 8;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    gptl_pkg::t_in_word  i_data = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    gptl_pkg::t_out_word o_data;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [2:0]          i_cfg_index = gptl_pkg::CFG_FOCAL_X;
    logic [31:0]         i_cfg_data = '0;

    ground_plane_target_locator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Local copy of the block's registers and held distance.
    logic [31:0]        focal_x_r = 32'h0001_0000;
    logic [31:0]        focal_y_r = 32'h0001_0000;
    logic [31:0]        center_x_r = '0;
    logic [31:0]        center_y_r = '0;
    logic signed [17:0] sin_r = '0;
    logic signed [17:0] cos_r = 18'sh10000;
    logic [31:0]        held_range = '0;

    gptl_pkg::t_out_word pending_points[$];
    int  src_idle = 24;
    int  snk_stall = 86;
    bit  failed = 1'b0;
    int  quiet_cycles = 0;

    function automatic logic signed [63:0] ray_part(logic [15:0] sum, logic [31:0] ctr,
                                                    logic [31:0] foc, inout bit sat);
        logic signed [63:0] diff;
        logic [63:0]        num;
        logic [63:0]        q;
        diff = $signed({34'd0, sum, 14'd0}) - $signed({32'd0, ctr});
        num = (diff < 0) ? 64'(-diff) : 64'(diff);
        num = num << 16;
        if (foc == 0) begin
            q = (num != 0) ? 64'(gptl_pkg::Cap31) : 64'd0;
            sat = 1'b1;
        end else begin
            q = num / {32'd0, foc};
            if (q > 64'(gptl_pkg::Cap31)) begin
                q = 64'(gptl_pkg::Cap31);
                sat = 1'b1;
            end
        end
        return (diff < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [31:0] cap_sign(logic signed [63:0] v);
        return (v > 0) ? gptl_pkg::Cap31 : ((v < 0) ? -gptl_pkg::Cap31 : 32'd0);
    endfunction

    function automatic logic [31:0] scale_point(logic signed [63:0] r, logic signed [63:0] t,
                                                logic [63:0] q, inout bit sat);
        logic [63:0] m;
        m = (((r < 0) ? 64'(-r) : 64'(r)) * q) >> 16;
        if (m > 64'(gptl_pkg::Cap31)) begin
            m = 64'(gptl_pkg::Cap31);
            sat = 1'b1;
        end
        return ((r < 0) != (t < 0)) ? 32'(-m) : 32'(m);
    endfunction

    // Returns 1 when the word yields a result word.
    function automatic bit locate_point(gptl_pkg::t_in_word w, output gptl_pkg::t_out_word p);
        bit                 sat;
        logic [15:0]        sx, sy;
        logic signed [63:0] rx, ry, s64, c64, den, t;
        logic [63:0]        dmag, q;
        sat = 1'b0;
        p = '0;
        if (!w.action) begin
            held_range = w.range_value;
            return 1'b0;
        end
        if (held_range == 0) return 1'b0;
        sx = 16'(w.top_left_x) + w.top_right_x + w.bottom_left_x + w.bottom_right_x;
        sy = 16'(w.top_left_y) + w.top_right_y + w.bottom_left_y + w.bottom_right_y;
        rx = ray_part(sx, center_x_r, focal_x_r, sat);
        ry = ray_part(sy, center_y_r, focal_y_r, sat);
        s64 = sin_r;
        c64 = cos_r;
        den = s64 * ry + c64 * 64'sd65536;
        if (den == 0) begin
            p.point_x = cap_sign(rx);
            p.point_y = cap_sign(ry);
            p.point_z = gptl_pkg::Cap31;
            p.status = gptl_pkg::ST_PARALLEL;
            return 1'b1;
        end
        dmag = (den < 0) ? 64'(-den) : 64'(den);
        q = {held_range, 32'd0} / dmag;
        if (q > 64'(gptl_pkg::Cap31)) begin
            q = 64'(gptl_pkg::Cap31);
            sat = 1'b1;
        end
        t = (den < 0) ? -$signed(q) : $signed(q);
        p.point_x = scale_point(rx, t, q, sat);
        p.point_y = scale_point(ry, t, q, sat);
        p.point_z = 32'(t);
        p.status = sat ? gptl_pkg::ST_SAT : gptl_pkg::ST_OK;
        return 1'b1;
    endfunction

    function automatic gptl_pkg::t_in_word range_word(logic [31:0] v);
        gptl_pkg::t_in_word w;
        w = '0;
        w.action = 1'b0;
        w.range_value = v;
        return w;
    endfunction

    function automatic gptl_pkg::t_in_word region_word(logic [11:0] tlx, logic [11:0] tly,
                                                       logic [11:0] trx, logic [11:0] try_y,
                                                       logic [11:0] blx, logic [11:0] bly,
                                                       logic [11:0] brx, logic [11:0] bry);
        gptl_pkg::t_in_word w;
        w.action = 1'b1;
        w.range_value = $urandom;
        w.top_left_x = tlx;
        w.top_left_y = tly;
        w.top_right_x = trx;
        w.top_right_y = try_y;
        w.bottom_left_x = blx;
        w.bottom_left_y = bly;
        w.bottom_right_x = brx;
        w.bottom_right_y = bry;
        return w;
    endfunction

    function automatic gptl_pkg::t_out_word point_of(logic [31:0] px, logic [31:0] py,
                                                     logic [31:0] pz, gptl_pkg::t_status st);
        gptl_pkg::t_out_word p;
        p.point_x = px;
        p.point_y = py;
        p.point_z = pz;
        p.status = st;
        return p;
    endfunction

    task automatic send_word(gptl_pkg::t_in_word w, t_check chk,
                             gptl_pkg::t_out_word fixed_pt);
        gptl_pkg::t_out_word p;
        bit                  has;
        while ($urandom_range(99) < src_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (!o_ready);
        has = locate_point(w, p);
        if (chk == CHK_FIXED) pending_points.push_back(fixed_pt);
        else if (chk == CHK_MODEL && has) pending_points.push_back(p);
        @(negedge i_clk);
    endtask

    task automatic settle_block();
        i_valid <= 1'b0;
        wait (pending_points.size() == 0);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_register(gptl_pkg::t_cfg_idx idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            gptl_pkg::CFG_FOCAL_X:  focal_x_r = val;
            gptl_pkg::CFG_FOCAL_Y:  focal_y_r = val;
            gptl_pkg::CFG_CENTER_X: center_x_r = val;
            gptl_pkg::CFG_CENTER_Y: center_y_r = val;
            gptl_pkg::CFG_SIN_TILT: sin_r = val[17:0];
            gptl_pkg::CFG_COS_TILT: cos_r = val[17:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_camera(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
                               logic [31:0] cy, int s, int c);
        write_register(gptl_pkg::CFG_FOCAL_X, fx);
        write_register(gptl_pkg::CFG_FOCAL_Y, fy);
        write_register(gptl_pkg::CFG_CENTER_X, cx);
        write_register(gptl_pkg::CFG_CENTER_Y, cy);
        write_register(gptl_pkg::CFG_SIN_TILT, 32'(s));
        write_register(gptl_pkg::CFG_COS_TILT, 32'(c));
    endtask

    function automatic logic [11:0] pick_coord();
        case ($urandom_range(9))
            0: return 12'd0;
            1: return 12'hFFF;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic gptl_pkg::t_in_word random_word();
        logic [31:0] v;
        if ($urandom_range(99) < 15) begin
            case ($urandom_range(19))
                0: v = 32'd0;
                1: v = 32'hFFFF_FFFF;
                2: v = $urandom;
                default: v = $urandom_range(32'h0040_0000, 1);
            endcase
            return range_word(v);
        end
        return region_word(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                           pick_coord(), pick_coord(), pick_coord(), pick_coord());
    endfunction

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= snk_stall);
    end

    always @(posedge i_clk) begin
        gptl_pkg::t_out_word e;
        if (o_valid && i_ready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected result word %h", o_data);
                failed = 1'b1;
            end else begin
                e = pending_points.pop_front();
                if (o_data.point_x !== e.point_x) begin
                    $error("point_x expected %h actual %h", e.point_x, o_data.point_x);
                    failed = 1'b1;
                end
                if (o_data.point_y !== e.point_y) begin
                    $error("point_y expected %h actual %h", e.point_y, o_data.point_y);
                    failed = 1'b1;
                end
                if (o_data.point_z !== e.point_z) begin
                    $error("point_z expected %h actual %h", e.point_z, o_data.point_z);
                    failed = 1'b1;
                end
                if (o_data.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_data.status);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchLimit) begin
            $display("FAIL ground_plane_target_locator");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_row                rows[$];
        t_row                r;
        gptl_pkg::t_out_word none;
        logic [11:0]         m;
        none = '0;
        m = 12'hFFF;
        rows.push_back('{region_word(0, 0, 0, 0, 0, 0, 0, 0), CHK_NONE, none});
        rows.push_back('{range_word(32'h0001_0000), CHK_NONE, none});
        rows.push_back('{region_word(0, 0, 0, 0, 0, 0, 0, 0), CHK_FIXED,
                         point_of(0, 0, 32'h0001_0000, gptl_pkg::ST_OK)});
        rows.push_back('{region_word(m, m, m, m, m, m, m, m), CHK_FIXED,
                         point_of(32'h0FFF_0000, 32'h0FFF_0000, 32'h0001_0000,
                                  gptl_pkg::ST_OK)});
        rows.push_back('{region_word(m, 0, 0, m, m, 0, 0, m), CHK_MODEL, none});
        rows.push_back('{region_word(12'h555, 12'hAAA, 12'hAAA, 12'h555, 1, 2, 3, 4),
                         CHK_MODEL, none});
        rows.push_back('{range_word(32'hFFFF_FFFF), CHK_NONE, none});
        rows.push_back('{region_word(0, 0, 0, 0, 0, 0, 0, 0), CHK_FIXED,
                         point_of(0, 0, gptl_pkg::Cap31, gptl_pkg::ST_SAT)});
        rows.push_back('{region_word(m, m, m, m, m, m, m, m), CHK_FIXED,
                         point_of(gptl_pkg::Cap31, gptl_pkg::Cap31, gptl_pkg::Cap31,
                                  gptl_pkg::ST_SAT)});
        r.w = region_word(m, m, m, m, m, m, m, m);
        r.w.action = 1'b0;
        r.w.range_value = 32'h0000_0001;
        rows.push_back('{r.w, CHK_NONE, none});
        rows.push_back('{region_word(m, m, m, m, m, m, m, m), CHK_MODEL, none});
        rows.push_back('{range_word(32'd0), CHK_NONE, none});
        rows.push_back('{region_word(m, m, m, m, m, m, m, m), CHK_NONE, none});
        rows.push_back('{range_word(32'h8000_0000), CHK_NONE, none});
        rows.push_back('{region_word(7, 9, 11, 13, 17, 19, 23, 29), CHK_MODEL, none});
        rows.push_back('{range_word(32'h0002_8000), CHK_NONE, none});

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) send_word(rows[i].w, rows[i].chk, rows[i].res);

        for (int ph = 0; ph < NumPhases; ph++) begin
            settle_block();
            if (ph == 3) begin
                src_idle = 86;
                snk_stall = 24;
            end else if (ph == 6) begin
                src_idle = 0;
                snk_stall = 0;
            end
            case (ph)
                0: load_camera(0, 0, 32'h0800_0000, 32'h0800_0000, 0, 65536);
                1: load_camera(32'h01F4_0000, 32'h01F4_0000, 32'h0800_0000,
                               32'h0800_0000, 0, 0);
                2: load_camera(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 65536, -65536);
                3: load_camera(32'h0001_0000, 32'h0001_0000, 0, 0, -65536, 0);
                default: load_camera({16'($urandom_range(2000, 1)), 16'($urandom)},
                                     {16'($urandom_range(2000, 1)), 16'($urandom)},
                                     {16'($urandom_range(4095)), 16'($urandom)},
                                     {16'($urandom_range(4095)), 16'($urandom)},
                                     int'($urandom_range(131072)) - 65536,
                                     int'($urandom_range(131072)) - 65536);
            endcase
            send_word(range_word($urandom_range(32'h0040_0000, 1)), CHK_MODEL, none);
            for (int k = 0; k < PhaseWords; k++) send_word(random_word(), CHK_MODEL, none);
        end

        settle_block();
        if (!failed && pending_points.size() == 0) begin
            $display("PASS ground_plane_target_locator");
        end else begin
            $display("FAIL ground_plane_target_locator");
        end
        $finish;
    end

endmodule

/* ground_plane_target_locator.f */
rtl/gptl_pkg.sv
rtl/gptl_front.sv
rtl/gptl_back.sv
rtl/ground_plane_target_locator.sv
tb/sv/tb_ground_plane_target_locator.sv
